// ===== src/resonant_lowpass_highpass_cascade_defines.svh =====
// Assertion macros used by the top-level RTL.
`ifndef RESONANT_LOWPASS_HIGHPASS_CASCADE_DEFINES_SVH
`define RESONANT_LOWPASS_HIGHPASS_CASCADE_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define RLHC_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the following cycle
`define RLHC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`else

`define RLHC_ASSERT_SAME(lbl, ck, rn, ante, cons, msg)
`define RLHC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)

`endif

`endif

// ===== src/rlhc_pkg.sv =====
package rlhc_pkg;

	// filter_mode codes
	localparam logic [1:0] MODE_BYPASS = 2'd0;
	localparam logic [1:0] MODE_HP     = 2'd1;
	localparam logic [1:0] MODE_LP     = 2'd2;
	localparam logic [1:0] MODE_BP     = 2'd3;

	// register indexes on the config port
	localparam int unsigned      CFG_IDX_W   = 3;
	localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LP_CUT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LP_DAMP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HP_CUT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HP_DAMP = 3'd4;

	// register reset values
	localparam logic [1:0]  RST_MODE    = MODE_BP;
	localparam logic [23:0] RST_LP_CUT  = 24'd2516582;
	localparam logic [23:0] RST_LP_DAMP = 24'd13421773;
	localparam logic [23:0] RST_HP_CUT  = 24'd167772;
	localparam logic [23:0] RST_HP_DAMP = 24'd16609444;

	// microprogram counter width
	localparam int unsigned UPC_W = 3;

	// multiplier B operand source
	typedef enum logic [1:0] {
		B_BAND,
		B_SECOND,
		B_DIFF
	} bsel_t;

	// one control word of the microprogram
	typedef struct packed {
		logic  a_cut;     // 1: cutoff coef, 0: damping coef
		bsel_t b_sel;
		logic  wr_band;   // write first state from acc + prod
		logic  wr_second; // write second state and next x
		logic  last;      // end of one filter stage
	} ucode_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_RUN,
		SEQ_FINISH
	} seq_state_t;

	// sequencer to datapath / top
	typedef struct packed {
		logic   idle;
		logic   load_x;
		logic   hp;
		ucode_t uw;
		logic   finish;
		logic   out_load;
	} ctrl_t;

	// Per stage: product pipeline prod_q -> acc_q, state written from acc_q + prod_q.
	//   0: damp*first
	//   1: cut*(x - second)
	//   2: first <= sum; damp*second
	//   3: cut*first (new)
	//   4: second <= sum; x updated; end of stage
	function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] upc);
		ucode_t w;
		w = '{a_cut: 1'b0, b_sel: B_BAND, wr_band: 1'b0, wr_second: 1'b0, last: 1'b0};
		unique case (upc)
			3'd0: w = '{a_cut: 1'b0, b_sel: B_BAND,   wr_band: 1'b0, wr_second: 1'b0,
				last: 1'b0};
			3'd1: w = '{a_cut: 1'b1, b_sel: B_DIFF,   wr_band: 1'b0, wr_second: 1'b0,
				last: 1'b0};
			3'd2: w = '{a_cut: 1'b0, b_sel: B_SECOND, wr_band: 1'b1, wr_second: 1'b0,
				last: 1'b0};
			3'd3: w = '{a_cut: 1'b1, b_sel: B_BAND,   wr_band: 1'b0, wr_second: 1'b0,
				last: 1'b0};
			3'd4: w = '{a_cut: 1'b0, b_sel: B_BAND,   wr_band: 1'b0, wr_second: 1'b1,
				last: 1'b1};
			default: w = '{a_cut: 1'b0, b_sel: B_BAND, wr_band: 1'b0, wr_second: 1'b0,
				last: 1'b1};
		endcase
		return w;
	endfunction

endpackage

// ===== src/rlhc_sequencer.sv =====
module rlhc_sequencer
	import rlhc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] mode,
	input  logic       out_free,
	output ctrl_t      ctrl
);

	seq_state_t       state_q, state_d;
	logic [UPC_W-1:0] upc_q, upc_d;
	logic             hp_q, hp_d;
	ucode_t           uw;

	assign uw = ucode_rom(upc_q);

	// state, step counter and stage select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			upc_q   <= '0;
			hp_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			upc_q   <= upc_d;
			hp_q    <= hp_d;
		end
	end

	// next state and control outputs
	always_comb begin
		state_d       = state_q;
		upc_d         = upc_q;
		hp_d          = hp_q;
		ctrl.idle     = 1'b0;
		ctrl.load_x   = 1'b0;
		ctrl.hp       = hp_q;
		ctrl.uw       = '{a_cut: 1'b0, b_sel: B_BAND, wr_band: 1'b0, wr_second: 1'b0,
			last: 1'b0};
		ctrl.finish   = 1'b0;
		ctrl.out_load = 1'b0;
		unique case (state_q)
			SEQ_IDLE: begin
				ctrl.idle = 1'b1;
				if (in_valid) begin
					ctrl.load_x = 1'b1;
					upc_d       = '0;
					hp_d        = (mode == MODE_HP);
					state_d     = (mode == MODE_BYPASS) ? SEQ_FINISH : SEQ_RUN;
				end
			end
			SEQ_RUN: begin
				ctrl.uw = uw;
				upc_d   = upc_q + 1'b1;
				if (uw.last) begin
					upc_d = '0;
					// lowpass done and bandpass selected: run the highpass next
					if (!hp_q && mode == MODE_BP) begin
						hp_d = 1'b1;
					end else begin
						state_d = SEQ_FINISH;
					end
				end
			end
			SEQ_FINISH: begin
				ctrl.finish = 1'b1;
				if (out_free) begin
					ctrl.out_load = 1'b1;
					state_d       = SEQ_IDLE;
				end
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

endmodule

// ===== src/rlhc_datapath.sv =====
module rlhc_datapath
	import rlhc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  ctrl_t              ctrl,
	input  logic signed [23:0] sample_in,
	input  logic [23:0]        lp_cut,
	input  logic [23:0]        lp_damp,
	input  logic [23:0]        hp_cut,
	input  logic [23:0]        hp_damp,
	output logic signed [23:0] sample_sat
);

	logic signed [31:0] lp_band_q, lp_out_q, hp_band_q, hp_low_q;
	logic signed [32:0] x_q;
	logic signed [58:0] prod_q, acc_q;

	logic signed [31:0] band, second, st_new;
	logic [23:0]        coef;
	logic signed [24:0] a_op;
	logic signed [33:0] diff, b_op, hp_res;
	logic signed [59:0] rnd;

	// stage operand select
	assign band   = ctrl.hp ? hp_band_q : lp_band_q;
	assign second = ctrl.hp ? hp_low_q : lp_out_q;
	assign coef   = ctrl.hp ? (ctrl.uw.a_cut ? hp_cut : hp_damp)
	                        : (ctrl.uw.a_cut ? lp_cut : lp_damp);
	assign a_op   = signed'({1'b0, coef});
	assign diff   = {x_q[32], x_q} - {{2{second[31]}}, second};

	always_comb begin
		unique case (ctrl.uw.b_sel)
			B_BAND:   b_op = {{2{band[31]}}, band};
			B_SECOND: b_op = {{2{second[31]}}, second};
			B_DIFF:   b_op = diff;
			default:  b_op = '0;
		endcase
	end

	// sum of the two products, round half up, floor shift, saturate to 32 bits
	assign rnd = {acc_q[58], acc_q} + {prod_q[58], prod_q} + 60'sd8388608;

	always_comb begin
		if (rnd[59:55] == 5'b00000 || rnd[59:55] == 5'b11111) begin
			st_new = rnd[55:24];
		end else begin
			st_new = rnd[59] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
	end

	// highpass output: x minus new second state
	assign hp_res = {x_q[32], x_q} - {{2{st_new[31]}}, st_new};

	// shared multiplier and product pipeline
	always_ff @(posedge clk) begin
		prod_q <= a_op * b_op;
		acc_q  <= prod_q;
	end

	// running sample value
	always_ff @(posedge clk) begin
		if (ctrl.load_x) begin
			x_q <= {{9{sample_in[23]}}, sample_in};
		end else if (ctrl.uw.wr_second) begin
			x_q <= ctrl.hp ? hp_res[32:0] : {st_new[31], st_new};
		end
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_band_q <= '0;
			lp_out_q  <= '0;
			hp_band_q <= '0;
			hp_low_q  <= '0;
		end else begin
			if (ctrl.uw.wr_band && !ctrl.hp)   lp_band_q <= st_new;
			if (ctrl.uw.wr_second && !ctrl.hp) lp_out_q  <= st_new;
			if (ctrl.uw.wr_band && ctrl.hp)    hp_band_q <= st_new;
			if (ctrl.uw.wr_second && ctrl.hp)  hp_low_q  <= st_new;
		end
	end

	// output saturation to 24 bits
	always_comb begin
		if (x_q[32:23] == 10'h000 || x_q[32:23] == 10'h3ff) begin
			sample_sat = x_q[23:0];
		end else begin
			sample_sat = x_q[32] ? 24'sh80_0000 : 24'sh7f_ffff;
		end
	end

endmodule

// ===== src/resonant_lowpass_highpass_cascade.sv =====
// channel   direction  handshake              word
// in        input      in_valid / in_ready    sample_in
// out       output     out_valid / out_ready  sample_out
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One sample at a time through one shared 25x34 multiplier under a 5-step microprogram
// per filter stage: none in bypass, one for lowpass or highpass, lowpass then highpass
// in bandpass. The result word is registered once the output register is free, after
// any wait for out_ready; the block then returns to idle to take the next word. The
// multiplier and its product pipeline set the step count. Reset clears filter state and
// restores register defaults; no clearing pass. A stalled output blocks the next sample.
`include "resonant_lowpass_highpass_cascade_defines.svh"

module resonant_lowpass_highpass_cascade
	import rlhc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [23:0]   sample_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [23:0]   sample_out,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [23:0]          cfg_data
);

	logic [1:0]         filter_mode_q;
	logic [23:0]        lp_cut_q, lp_damp_q, hp_cut_q, hp_damp_q;
	logic               out_valid_q;
	logic signed [23:0] sample_out_q;
	logic signed [23:0] sample_sat;
	logic               out_free;
	ctrl_t              ctrl;

	assign cfg_ready  = 1'b1;
	assign in_ready   = ctrl.idle;
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign out_free   = !out_valid_q || out_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_mode_q <= RST_MODE;
			lp_cut_q      <= RST_LP_CUT;
			lp_damp_q     <= RST_LP_DAMP;
			hp_cut_q      <= RST_HP_CUT;
			hp_damp_q     <= RST_HP_DAMP;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MODE:    filter_mode_q <= cfg_data[1:0];
				REG_LP_CUT:  lp_cut_q      <= cfg_data;
				REG_LP_DAMP: lp_damp_q     <= cfg_data;
				REG_HP_CUT:  hp_cut_q      <= cfg_data;
				REG_HP_DAMP: hp_damp_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	rlhc_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (filter_mode_q),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	rlhc_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.sample_in  (sample_in),
		.lp_cut     (lp_cut_q),
		.lp_damp    (lp_damp_q),
		.hp_cut     (hp_cut_q),
		.hp_damp    (hp_damp_q),
		.sample_sat (sample_sat)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			sample_out_q <= sample_sat;
		end
	end

	// checks
	`RLHC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n,
		in_valid && in_ready, !in_ready, "accepted word did not leave idle")
	`RLHC_ASSERT_SAME(a_no_state_write_idle, clk, arst_n,
		in_ready, !ctrl.uw.wr_band && !ctrl.uw.wr_second, "filter state written while idle")
	`RLHC_ASSERT_NEXT(a_bypass_direct, clk, arst_n,
		in_valid && in_ready && filter_mode_q == MODE_BYPASS, ctrl.finish,
		"bypass word did not go straight to output")
	`RLHC_ASSERT_SAME(a_load_when_free, clk, arst_n,
		ctrl.out_load, !out_valid_q || out_ready, "output register overwritten")

endmodule

// ===== sim/cascade_checker.sv =====
module cascade_checker
	import rlhc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic signed [23:0]   sample_in,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic signed [23:0]   sample_out,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [23:0]          cfg_data,
	output int                   failures,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint STATE_MAX = (longint'(1) << 31) - 1;
	localparam longint STATE_MIN = -(longint'(1) << 31);
	localparam longint OUT_MAX   = 8388607;
	localparam longint OUT_MIN   = -8388608;
	localparam longint HALF_LSB  = longint'(1) << 23;
	localparam int     SHOW_MAX  = 10;

	// shadow registers
	logic [1:0]  mode;
	logic [23:0] lp_cut, lp_damp, hp_cut, hp_damp;

	// shadow filter state, Q8.23
	int lp_band, lp_second, hp_band, hp_second;

	// predicted output words, oldest first
	logic signed [23:0] expected_out[$];
	logic signed [23:0] want;

	// damp*s + cut*d in Q.47, rounded half up to Q.23, clipped to 32 bits
	function automatic int mac_round(logic [23:0] damp, int s, logic [23:0] cut, longint d);
		longint acc;
		acc = (longint'(damp) * longint'(s) + longint'(cut) * d + HALF_LSB) >>> 24;
		if (acc > STATE_MAX)
			return int'(STATE_MAX);
		if (acc < STATE_MIN)
			return int'(STATE_MIN);
		return int'(acc);
	endfunction

	// one sample through the selected stages; updates the shadow state
	function automatic logic signed [23:0] filter_sample(input logic signed [23:0] smp);
		longint x;
		x = longint'(smp);
		// lowpass: full 32-bit output feeds the highpass
		if (mode == MODE_LP || mode == MODE_BP) begin
			lp_band   = mac_round(lp_damp, lp_band, lp_cut, x - longint'(lp_second));
			lp_second = mac_round(lp_damp, lp_second, lp_cut, longint'(lp_band));
			x = longint'(lp_second);
		end
		// highpass: input minus its second value
		if (mode == MODE_HP || mode == MODE_BP) begin
			hp_band   = mac_round(hp_damp, hp_band, hp_cut, x - longint'(hp_second));
			hp_second = mac_round(hp_damp, hp_second, hp_cut, longint'(hp_band));
			x = x - longint'(hp_second);
		end
		if (x > OUT_MAX)
			x = OUT_MAX;
		if (x < OUT_MIN)
			x = OUT_MIN;
		return x[23:0];
	endfunction

	// watch all three channels at each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode      = RST_MODE;
			lp_cut    = RST_LP_CUT;
			lp_damp   = RST_LP_DAMP;
			hp_cut    = RST_HP_CUT;
			hp_damp   = RST_HP_DAMP;
			lp_band   = 0;
			lp_second = 0;
			hp_band   = 0;
			hp_second = 0;
			failures  = 0;
			expected_out.delete();
			pending <= 0;
		end else begin
			// register writes; unknown indexes are dropped
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODE:    mode    = cfg_data[1:0];
					REG_LP_CUT:  lp_cut  = cfg_data;
					REG_LP_DAMP: lp_damp = cfg_data;
					REG_HP_CUT:  hp_cut  = cfg_data;
					REG_HP_DAMP: hp_damp = cfg_data;
					default: ;
				endcase
			end
			// compare an output word with the oldest prediction
			if (out_valid && out_ready) begin
				if (expected_out.size() == 0) begin
					failures++;
					if (failures <= SHOW_MAX)
						$display("ERROR: sample_out %0d arrived with no sample pending",
							sample_out);
				end else begin
					want = expected_out.pop_front();
					if (sample_out !== want) begin
						failures++;
						if (failures <= SHOW_MAX)
							$display("ERROR: sample_out expected %0d got %0d",
								want, sample_out);
					end
				end
			end
			// predict each accepted input word
			if (in_valid && in_ready)
				expected_out.push_back(filter_sample(sample_in));
			pending <= expected_out.size();
		end
	end

endmodule

// ===== sim/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rlhc_pkg::*;

	localparam logic signed [23:0] FULL_POS = 24'sh7FFFFF;
	localparam logic signed [23:0] FULL_NEG = 24'sh800000;
	localparam logic [23:0]        COEF_MAX = 24'hFFFFFF;
	localparam int QUIET_LIMIT = 5000;
	localparam int TAIL_CYCLES = 24;
	localparam int PHASES      = 15;
	localparam int PHASE_WORDS = 92;
	localparam int RING_WORDS  = 600;
	localparam int RING_PHASE  = 2;

	typedef enum int {SHAPE_SQUARE, SHAPE_NOISE, SHAPE_CORNER, SHAPE_QUIET, SHAPE_DC} shape_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic signed [23:0]   sample_in = '0;
	logic                 out_ready = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [23:0]          cfg_data  = '0;
	logic                 in_ready, out_valid, cfg_ready;
	logic signed [23:0]   sample_out;

	int bad_words, words_in_flight;
	int in_idle_pct   = 0;
	int out_stall_pct = 0;
	int quiet_cycles  = 0;
	int n_samples     = 0;
	int n_writes      = 0;

	logic [1:0]         mode_list[4]   = '{MODE_BYPASS, MODE_HP, MODE_LP, MODE_BP};
	int                 idle_tab[4]    = '{0, 71, 0, 25};
	int                 stall_tab[4]   = '{0, 0, 71, 25};
	logic signed [23:0] corner_vals[5] = '{FULL_POS, FULL_NEG, 24'sd0, 24'sd1, -24'sd1};

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	resonant_lowpass_highpass_cascade u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	cascade_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample_out (sample_out),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.failures   (bad_words),
		.pending    (words_in_flight)
	);

	// receiver back-pressure
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= out_stall_pct);

	// watchdog: too long with no word moving on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("resonant_lowpass_highpass_cascade: mismatch");
			$finish;
		end
	end

	// send one sample word, with a random idle gap ahead of it
	task automatic push_sample(input logic signed [23:0] v);
		int gap;
		gap = 0;
		while ($urandom_range(99) < in_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= v;
		do @(posedge clk); while (!in_ready);
		n_samples++;
	endtask

	// stop sending and wait until every predicted word has come back
	task automatic wait_drained;
		in_valid <= 1'b0;
		do @(posedge clk); while (words_in_flight != 0);
	endtask

	// one register write; valid stays up for back-to-back writes
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		n_writes++;
	endtask

	// coefficient choice: zeros first, then full scale, then a mix
	function automatic logic [23:0] coef_for(input int ph);
		if (ph == 0)
			return '0;
		if (ph <= RING_PHASE)
			return COEF_MAX;
		case ($urandom_range(9))
			0:       return '0;
			1:       return COEF_MAX;
			2:       return COEF_MAX - 24'($urandom_range(4095));
			3:       return 24'($urandom_range(65535));
			default: return 24'($urandom());
		endcase
	endfunction

	// program all registers for one phase and pick its idle and stall mix
	task automatic setup_phase(input int ph);
		logic [23:0] mode_word;
		mode_word      = 24'($urandom());
		mode_word[1:0] = (ph == RING_PHASE) ? MODE_BP : mode_list[ph % 4];
		wait_drained();
		write_reg(REG_MODE, mode_word);
		write_reg(REG_LP_CUT, coef_for(ph));
		write_reg(REG_LP_DAMP, coef_for(ph));
		write_reg(REG_HP_CUT, coef_for(ph));
		write_reg(REG_HP_DAMP, coef_for(ph));
		// writes past the last register must be dropped
		if ($urandom_range(2) == 0)
			write_reg(CFG_IDX_W'(REG_HP_DAMP + 1 + $urandom_range(2)), 24'($urandom()));
		cfg_valid     <= 1'b0;
		in_idle_pct   = idle_tab[(ph + ph / 4) % 4];
		out_stall_pct = stall_tab[(ph + ph / 4) % 4];
	endtask

	// signal runs: mostly square waves, plus noise, corners, quiet and DC
	task automatic play_signal(input int count, input bit ring, input bit hold_mid);
		int sent, k, run_len, period, r;
		shape_t shape;
		logic signed [23:0] amp, level, v;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(9);
			shape = ring ? SHAPE_SQUARE :
				(r < 5) ? SHAPE_SQUARE : (r < 7) ? SHAPE_NOISE :
				(r == 7) ? SHAPE_CORNER : (r == 8) ? SHAPE_QUIET : SHAPE_DC;
			run_len = ring ? count : $urandom_range(8, 60);
			period  = ring ? 6 : $urandom_range(2, 40);
			amp     = (ring || $urandom_range(1) == 0) ? FULL_POS :
				24'($urandom_range(8388607));
			level   = 24'($urandom());
			for (k = 0; k < run_len && sent < count; k++) begin
				case (shape)
					SHAPE_NOISE:  v = 24'($urandom());
					SHAPE_CORNER: v = corner_vals[$urandom_range(4)];
					SHAPE_QUIET:  v = 24'($urandom_range(511)) - 24'sd256;
					SHAPE_DC:     v = level;
					default:      v = ((k % period) < period / 2) ? amp : -amp;
				endcase
				// hold off mid-run until the block has emptied
				if (hold_mid && sent == count / 2)
					wait_drained();
				push_sample(v);
				sent++;
			end
		end
	endtask

	initial begin
		int k, ph;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// register defaults: bandpass
		push_sample(24'sd0);
		push_sample(FULL_POS);
		push_sample(FULL_POS);
		push_sample(FULL_NEG);
		push_sample(FULL_NEG);
		push_sample(24'sd1);
		push_sample(-24'sd1);

		// bypass, and writes to indexes past the last register
		wait_drained();
		write_reg(REG_MODE, 24'(MODE_BYPASS));
		write_reg(CFG_IDX_W'(REG_HP_DAMP + 1), '1);
		write_reg(CFG_IDX_W'(REG_HP_DAMP + 3), '1);
		cfg_valid <= 1'b0;
		push_sample(FULL_POS);
		push_sample(FULL_NEG);
		push_sample(24'sd0);
		push_sample(24'sh555555);
		push_sample(24'shAAAAAA);

		// lowpass at full-scale coefficients, driven at resonance
		wait_drained();
		write_reg(REG_MODE, 24'(MODE_LP));
		write_reg(REG_LP_CUT, COEF_MAX);
		write_reg(REG_LP_DAMP, COEF_MAX);
		cfg_valid <= 1'b0;
		for (k = 0; k < 6; k++)
			push_sample(k < 3 ? FULL_POS : FULL_NEG);

		// highpass the same way; output clips within a few words
		wait_drained();
		write_reg(REG_MODE, 24'(MODE_HP));
		write_reg(REG_HP_CUT, COEF_MAX);
		write_reg(REG_HP_DAMP, COEF_MAX);
		cfg_valid <= 1'b0;
		for (k = 0; k < 6; k++)
			push_sample(k < 3 ? FULL_POS : FULL_NEG);

		// random phases; one long resonant run drives the state into saturation
		for (ph = 0; ph < PHASES; ph++) begin
			setup_phase(ph);
			play_signal(ph == RING_PHASE ? RING_WORDS : PHASE_WORDS, ph == RING_PHASE,
				ph % 5 == 3);
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d samples and %0d register writes: all four modes, zero and",
			n_samples, n_writes);
		$display("full-scale coefficients, resonant saturation, idle and stall mixes.");
		if (bad_words == 0 && words_in_flight == 0)
			$display("resonant_lowpass_highpass_cascade: match");
		else
			$display("resonant_lowpass_highpass_cascade: mismatch");
		$finish;
	end

endmodule
